// File: hw/rtl/dfa_pkg.sv
// Shared types, codes and helpers of the DMA frame allocator.
// Depends on nothing; the allocator and its checker take names from here.
`default_nettype none

package dfa_pkg;

   // Default geometry of the frame region.
   localparam int FRAME_COUNT_DEFAULT = 32;
   localparam int FRAME_BYTES_DEFAULT = 4096;

   // Field widths of the request and response words.
   localparam int ADDR_W   = 32;
   localparam int INDEX_W  = 5;
   localparam int STATUS_W = 2;

   // Register port geometry: one 32-bit register, byte addressed.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_REG_W  = CSR_ADDR_W - 2;

   // Width of the lowest-set-bit search.
   localparam int SEARCH_W   = 32;
   localparam int SEARCH_POS = 5;

   // Request actions.
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

   // Register indexes.
   localparam logic [CSR_REG_W-1:0] REG_BASE_ADDRESS = 1'b0;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   frame_address;
      logic [INDEX_W-1:0]  frame_index;
   } rsp_payload_type;

   // Position of the lowest set bit; zero when no bit is set.
   // The lowest bit is isolated first, so the encode is an OR over independent bits.
   function automatic logic [SEARCH_POS-1:0] first_set(input logic [SEARCH_W-1:0] v);
      logic [SEARCH_W-1:0]   lowest;
      logic [SEARCH_POS-1:0] pos;
      lowest = v & (~v + SEARCH_W'(1));
      pos    = '0;
      for (int i = 0; i < SEARCH_W; i++) begin
         if (lowest[i]) begin
            pos = pos | SEARCH_POS'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dma_frame_allocator_unit.sv
// Top level of the DMA frame allocator: free map memory, sequencer and register port.
// Depends on dfa_pkg for the word types, codes and the lowest-set-bit search.
//
//   Channel   Direction   Handshake            Word
//   req_      in          req_valid/req_stall  action, address
//   rsp_      out         rsp_valid/rsp_stall  status, frame_address, frame_index
//   csr_      in/out      APB, pready high     base_address at byte address 0
//
// An allocate passes the row read, picked from the per-row full flags and started at
// acceptance, then the write-back with the index multiply, the base add and the output
// register. A free passes the range check, the reciprocal multiply with the row read,
// the write-back and the output register. A bad address goes from the range check to
// the output register, and a full map goes there at once; the next word can be taken in
// the same cycle as a result appears. Reset is synchronous; per-row valid bits make the
// whole map read as free at once, with no clearing pass. A finished word waits in the
// output register while rsp_stall is high.
`default_nettype none

module dma_frame_allocator_unit #(
   parameter int FRAME_COUNT = dfa_pkg::FRAME_COUNT_DEFAULT,
   parameter int FRAME_BYTES = dfa_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dfa_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dfa_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dfa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dfa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dfa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   // Free map geometry: rows of up to 32 frames, one memory word per row.
   localparam int ROW_BITS  = (FRAME_COUNT < dfa_pkg::SEARCH_W) ? FRAME_COUNT
                                                                 : dfa_pkg::SEARCH_W;
   localparam int ROWS      = (FRAME_COUNT + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_AW    = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
   localparam int IDX_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int REGION_BYTES = FRAME_COUNT * FRAME_BYTES;
   localparam int REM_W     = $clog2(REGION_BYTES + 1);
   localparam int PROD_W    = IDX_W + $clog2(FRAME_BYTES + 1);
   localparam int LAST_BITS = FRAME_COUNT - (ROWS - 1) * ROW_BITS;
   localparam logic [ROW_BITS-1:0] LAST_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - LAST_BITS);
   localparam logic [ROW_AW-1:0]   LAST_ROW  = ROW_AW'(ROWS - 1);

   // Reciprocal of FRAME_BYTES, rounded up; exact for every offset below 2**REM_W.
   localparam int     DIV_S = REM_W + $clog2(FRAME_BYTES);
   localparam longint DIV_M = ((longint'(1) << DIV_S) + longint'(FRAME_BYTES) - 1)
                              / longint'(FRAME_BYTES);
   localparam int     MUL_W = 2 * REM_W + 1;
   localparam logic [REM_W:0] RECIP = (REM_W + 1)'(DIV_M);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_ALLOC   = 7'b0000010,
      S_ADDR    = 7'b0000100,
      S_CHECK   = 7'b0001000,
      S_DIV     = 7'b0010000,
      S_FREE_WR = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [dfa_pkg::ADDR_W-1:0]         base_ff, base_in;
   logic [dfa_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [REM_W-1:0]                   rem_ff, rem_in;
   logic [IDX_W-1:0]                   quot_ff, quot_in;
   logic [ROW_AW-1:0]                  row_ff, row_in;
   logic [PROD_W-1:0]                  prod_ff, prod_in;
   dfa_pkg::rsp_payload_type           res_ff, res_in;
   dfa_pkg::rsp_payload_type           rsp_data_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ROWS-1:0]                    row_valid_ff, row_valid_in;
   logic [ROWS-1:0]                    row_full_ff, row_full_in;
   logic [ROW_BITS-1:0]                free_map_ff [ROWS];
   logic [ROW_BITS-1:0]                mem_q_ff;

   logic                               mem_rd_en;
   logic                               mem_wr_en;
   logic [ROW_BITS-1:0]                mem_wr_data;
   logic                               load_rsp;
   logic                               csr_write;
   logic [dfa_pkg::CSR_REG_W-1:0]      csr_reg;
   logic [ROWS-1:0]                    row_open;
   logic [dfa_pkg::SEARCH_W-1:0]       avail_rows;
   logic [ROW_AW-1:0]                  first_row;
   logic [ROW_BITS-1:0]                cur_row;
   logic [BIT_AW-1:0]                  alloc_bit;
   logic [ROW_BITS-1:0]                alloc_row_new;
   logic [BIT_AW-1:0]                  free_bit;
   logic [ROW_BITS-1:0]                free_row_new;
   logic [IDX_W-1:0]                   alloc_idx;
   logic                               below_base;
   logic [dfa_pkg::ADDR_W-1:0]         offset;
   logic                               past_end;
   logic [MUL_W-1:0]                   quot_prod;

   // Register port: only base_address exists; other indexes read as zero.
   assign csr_pready = 1'b1;
   assign csr_reg    = csr_paddr[dfa_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_reg == dfa_pkg::REG_BASE_ADDRESS) ? base_ff : '0;

   always_comb begin
      base_in = base_ff;
      if (csr_write && (csr_reg == dfa_pkg::REG_BASE_ADDRESS)) begin
         base_in = csr_pwdata;
      end
   end

   // Handshake outputs.
   assign req_stall = reset | (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Rows that still hold a free frame; the lowest one is searched first.
   assign row_open   = ~row_full_ff;
   assign avail_rows = dfa_pkg::SEARCH_W'(row_open);
   assign first_row  = ROW_AW'(dfa_pkg::first_set(avail_rows));

   // Row word as read; a row never written reads as all of its frames free.
   always_comb begin
      if (row_valid_ff[row_ff]) begin
         cur_row = mem_q_ff;
      end else if (row_ff == LAST_ROW) begin
         cur_row = LAST_MASK;
      end else begin
         cur_row = '1;
      end
   end

   // Allocate takes the lowest free bit of the row; free sets the bit of the quotient.
   assign alloc_bit     = BIT_AW'(dfa_pkg::first_set(dfa_pkg::SEARCH_W'(cur_row)));
   assign alloc_row_new = cur_row & ~(ROW_BITS'(1) << alloc_bit);
   assign alloc_idx     = IDX_W'({row_ff, alloc_bit});
   assign free_bit      = quot_ff[BIT_AW-1:0];
   assign free_row_new  = cur_row | (ROW_BITS'(1) << free_bit);

   // Range check of a free address against the region.
   assign below_base = addr_ff < base_ff;
   assign offset     = addr_ff - base_ff;
   assign past_end   = offset >= dfa_pkg::ADDR_W'(REGION_BYTES);

   // Frame index of the offset: multiply by the constant reciprocal and drop the fraction.
   assign quot_prod = MUL_W'(rem_ff) * MUL_W'(RECIP);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      row_in       = row_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      row_valid_in = row_valid_ff;
      row_full_in  = row_full_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_data  = cur_row;
      load_rsp     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               addr_in = req_data.address;
               if (req_data.action == dfa_pkg::ACTION_FREE) begin
                  state_in = S_CHECK;
               end else if (avail_rows == '0) begin
                  res_in   = '{status: dfa_pkg::STATUS_FULL, frame_address: '0,
                               frame_index: '0};
                  state_in = S_FINISH;
               end else begin
                  row_in    = first_row;
                  mem_rd_en = 1'b1;
                  state_in  = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            mem_wr_en            = 1'b1;
            mem_wr_data          = alloc_row_new;
            row_valid_in[row_ff] = 1'b1;
            row_full_in[row_ff]  = ~|alloc_row_new;
            quot_in              = alloc_idx;
            prod_in              = PROD_W'(alloc_idx) * PROD_W'(FRAME_BYTES);
            state_in             = S_ADDR;
         end
         S_ADDR: begin
            res_in   = '{status: dfa_pkg::STATUS_OK,
                         frame_address: base_ff + dfa_pkg::ADDR_W'(prod_ff),
                         frame_index: dfa_pkg::INDEX_W'(quot_ff)};
            state_in = S_FINISH;
         end
         S_CHECK: begin
            if (below_base || past_end) begin
               res_in   = '{status: dfa_pkg::STATUS_BAD_ADDR, frame_address: '0,
                            frame_index: '0};
               state_in = S_FINISH;
            end else begin
               rem_in   = REM_W'(offset);
               quot_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            quot_in   = IDX_W'(quot_prod >> DIV_S);
            row_in    = ROW_AW'(quot_in >> BIT_AW);
            mem_rd_en = 1'b1;
            state_in  = S_FREE_WR;
         end
         S_FREE_WR: begin
            mem_wr_en            = 1'b1;
            mem_wr_data          = free_row_new;
            row_valid_in[row_ff] = 1'b1;
            row_full_in[row_ff]  = 1'b0;
            res_in               = '{status: dfa_pkg::STATUS_OK, frame_address: '0,
                                     frame_index: dfa_pkg::INDEX_W'(quot_ff)};
            state_in             = S_FINISH;
         end
         S_FINISH: begin
            // Hand the word over once the output register is empty or being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         row_full_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         row_full_ff  <= row_full_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      row_ff  <= row_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Free map memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         free_map_ff[row_ff] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_q_ff <= free_map_ff[row_in];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dfa_checker.sv
// Port-level checker for the DMA frame allocator, bound to its top level.
// Depends on dfa_pkg for the word types, status codes and register index.
`default_nettype none

module dfa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input dfa_pkg::rsp_payload_type         rsp_data,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [dfa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [dfa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [dfa_pkg::CSR_DATA_W-1:0]   csr_prdata
);

   // One word at a time: an accepted request holds off the next one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous word was still in work");

   // A stalled response word stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response word dropped or changed");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == dfa_pkg::STATUS_OK ||
                     rsp_data.status == dfa_pkg::STATUS_FULL ||
                     rsp_data.status == dfa_pkg::STATUS_BAD_ADDR))
      else $error("undefined response status");

   // A failed request carries a zero address and index.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != dfa_pkg::STATUS_OK) |->
      (rsp_data.frame_address == '0 && rsp_data.frame_index == '0))
      else $error("error response with nonzero address or index");

   // The base register reads back what was just written.
   a_base_readback: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) &&
       $past(csr_psel && csr_penable && csr_pwrite &&
             csr_paddr[dfa_pkg::CSR_ADDR_W-1:2] == dfa_pkg::REG_BASE_ADDRESS) &&
       csr_paddr[dfa_pkg::CSR_ADDR_W-1:2] == dfa_pkg::REG_BASE_ADDRESS) |->
      (csr_prdata == $past(csr_pwdata)))
      else $error("base_address read back differs from the value written");

endmodule

bind dma_frame_allocator_unit dfa_checker u_dfa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire
